// File: rtl/bsc_pkg.sv
// shared types, widths and constants for the barometric sensor compensation block
package bsc_pkg;

   // field widths
   localparam int RAW_W     = 24;
   localparam int COEF_W    = 16;
   localparam int TEMP_W    = 19;
   localparam int PRESS_W   = 32;
   localparam int CSR_IDX_W = 3;

   // shift amounts of the calibration formulae
   localparam int C5_SHIFT        = 8;
   localparam int TEMP_SHIFT      = 23;
   localparam int OFF_C2_SHIFT    = 17;
   localparam int OFF_DT_SHIFT    = 6;
   localparam int SENS_C1_SHIFT   = 16;
   localparam int SENS_DT_SHIFT   = 7;
   localparam int PRESS_MUL_SHIFT = 21;
   localparam int PRESS_OUT_SHIFT = 16;

   localparam int TEMP_BASE = 2000;
   localparam int TEMP_MIN  = -140000;
   localparam int TEMP_MAX  = 140000;

   // internal widths
   localparam int DT_W       = RAW_W + 1;
   localparam int PROD_W     = DT_W + COEF_W + 1;
   localparam int TEMP_SUM_W = TEMP_W + 1;
   localparam int OFF_W      = 37;
   localparam int SENS_W     = 36;
   localparam int SPLIT_W    = 18;
   localparam int PP_LO_W    = RAW_W + SPLIT_W;
   localparam int PP_HI_W    = RAW_W + 1 + SENS_W - SPLIT_W;
   localparam int FULL_W     = 62;
   localparam int QUOT_W     = FULL_W - PRESS_MUL_SHIFT;
   localparam int DIFF_W     = QUOT_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      COEF_C1 = 3'd0,
      COEF_C2 = 3'd1,
      COEF_C3 = 3'd2,
      COEF_C4 = 3'd3,
      COEF_C5 = 3'd4,
      COEF_C6 = 3'd5
   } coef_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] c1;
      logic [COEF_W-1:0] c2;
      logic [COEF_W-1:0] c3;
      logic [COEF_W-1:0] c4;
      logic [COEF_W-1:0] c5;
      logic [COEF_W-1:0] c6;
   } coef_set_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
      logic [RAW_W-1:0]         raw_press;
   } calib_type;

endpackage

// File: rtl/baro_sensor_compensation.sv
// top level of the barometric sensor first-order compensation pipeline
//
// takes one item (raw temperature and raw pressure reading) in every clock cycle
// and returns one compensated item per input, in order, after its pipeline stages;
// busy is never raised, so start may be held high continuously. results are shown
// on the rsp_ ports for exactly one cycle marked by rsp_valid and cannot be held
// off. each item passes through the six-stage pipeline: dT, the three
// coefficient products, temp/off/sens, the split 24 x 36 pressure product, its
// recombination and shift, and the final offset subtraction. coefficients are
// written through the csr_ port and must only change while no item is in flight
module baro_sensor_compensation (
   input  logic                                clock,
   input  logic                                reset,
   // command side
   input  logic                                start,
   output logic                                busy,
   input  logic [bsc_pkg::RAW_W-1:0]           req_raw_temp,
   input  logic [bsc_pkg::RAW_W-1:0]           req_raw_press,
   // result side
   output logic                                rsp_valid,
   output logic signed [bsc_pkg::TEMP_W-1:0]   rsp_temp_centi,
   output logic signed [bsc_pkg::PRESS_W-1:0]  rsp_press_centi,
   // coefficient write port
   input  logic                                csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bsc_pkg::COEF_W-1:0]          csr_wdata
);

   bsc_pkg::coef_set_type coefs;
   bsc_pkg::calib_type    calib_data;
   logic                  calib_valid;
   logic                  accept;

   // fully pipelined, no back-pressure anywhere
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   bsc_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coefs     (coefs)
   );

   // dT, products and first-order terms
   bsc_calib u_calib (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .raw_temp  (req_raw_temp),
      .raw_press (req_raw_press),
      .coefs     (coefs),
      .out_valid (calib_valid),
      .out_data  (calib_data)
   );

   // pressure product, shift and offset
   bsc_press u_press (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (calib_valid),
      .in_data     (calib_data),
      .out_valid   (rsp_valid),
      .temp_centi  (rsp_temp_centi),
      .press_centi (rsp_press_centi)
   );

`ifndef ASSERT_OFF
   // every result stems from an earlier accepted item
   a_rsp_has_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("result without a matching item");

   // every accepted item yields its result at the pipeline output
   a_item_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("item lost in the pipeline");

   // temperature stays within its saturated range
   a_temp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temp_centi <= bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MAX)) &&
                    (rsp_temp_centi >= bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MIN)))
      else $error("temperature outside saturation range");

   // reset flushes the pipeline
   a_reset_flush : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe after reset");
`endif

endmodule

// File: rtl/bsc_coef_regs.sv
// calibration coefficient register file with plain write port
module bsc_coef_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsc_pkg::COEF_W-1:0]        csr_wdata,
   output bsc_pkg::coef_set_type             coefs
);

   bsc_pkg::coef_set_type coef_ff;
   bsc_pkg::coef_set_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         case (csr_index)
            bsc_pkg::COEF_C1: coef_in.c1 = csr_wdata;
            bsc_pkg::COEF_C2: coef_in.c2 = csr_wdata;
            bsc_pkg::COEF_C3: coef_in.c3 = csr_wdata;
            bsc_pkg::COEF_C4: coef_in.c4 = csr_wdata;
            bsc_pkg::COEF_C5: coef_in.c5 = csr_wdata;
            bsc_pkg::COEF_C6: coef_in.c6 = csr_wdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coefs = coef_ff;

endmodule

// File: rtl/bsc_calib.sv
// stages one to three: dT, the three coefficient products, temp/off/sens
module bsc_calib (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [bsc_pkg::RAW_W-1:0]     raw_temp,
   input  logic [bsc_pkg::RAW_W-1:0]     raw_press,
   input  bsc_pkg::coef_set_type         coefs,
   output logic                          out_valid,
   output bsc_pkg::calib_type            out_data
);

   // stage one
   logic                               v1_ff;
   logic signed [bsc_pkg::DT_W-1:0]    dt_ff, dt_in;
   logic [bsc_pkg::RAW_W-1:0]          rp1_ff;
   // stage two
   logic                               v2_ff;
   logic signed [bsc_pkg::PROD_W-1:0]  prod_t_ff, prod_t_in;
   logic signed [bsc_pkg::PROD_W-1:0]  prod_o_ff, prod_o_in;
   logic signed [bsc_pkg::PROD_W-1:0]  prod_s_ff, prod_s_in;
   logic [bsc_pkg::RAW_W-1:0]          rp2_ff;
   // stage three
   logic                               v3_ff;
   bsc_pkg::calib_type                 res_ff, res_in;
   logic signed [bsc_pkg::TEMP_SUM_W-1:0] temp_sum;

   // dT = raw_t - c5 * 2^8
   always_comb begin
      dt_in = $signed({1'b0, raw_temp})
            - $signed({1'b0, coefs.c5, {bsc_pkg::C5_SHIFT{1'b0}}});
   end

   always_comb begin
      prod_t_in = bsc_pkg::PROD_W'(dt_ff) * bsc_pkg::PROD_W'($signed({1'b0, coefs.c6}));
      prod_o_in = bsc_pkg::PROD_W'(dt_ff) * bsc_pkg::PROD_W'($signed({1'b0, coefs.c4}));
      prod_s_in = bsc_pkg::PROD_W'(dt_ff) * bsc_pkg::PROD_W'($signed({1'b0, coefs.c3}));
   end

   always_comb begin
      temp_sum = bsc_pkg::TEMP_SUM_W'(
                    $signed(prod_t_ff[bsc_pkg::PROD_W-1:bsc_pkg::TEMP_SHIFT]))
               + bsc_pkg::TEMP_SUM_W'(bsc_pkg::TEMP_BASE);
      if (temp_sum > bsc_pkg::TEMP_SUM_W'(bsc_pkg::TEMP_MAX)) begin
         res_in.temp = bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MAX);
      end else if (temp_sum < bsc_pkg::TEMP_SUM_W'(bsc_pkg::TEMP_MIN)) begin
         res_in.temp = bsc_pkg::TEMP_W'(bsc_pkg::TEMP_MIN);
      end else begin
         res_in.temp = temp_sum[bsc_pkg::TEMP_W-1:0];
      end
      res_in.off =
         $signed({{(bsc_pkg::OFF_W - bsc_pkg::COEF_W - bsc_pkg::OFF_C2_SHIFT){1'b0}},
                  coefs.c2, {bsc_pkg::OFF_C2_SHIFT{1'b0}}})
         + bsc_pkg::OFF_W'($signed(prod_o_ff[bsc_pkg::PROD_W-1:bsc_pkg::OFF_DT_SHIFT]));
      res_in.sens =
         $signed({{(bsc_pkg::SENS_W - bsc_pkg::COEF_W - bsc_pkg::SENS_C1_SHIFT){1'b0}},
                  coefs.c1, {bsc_pkg::SENS_C1_SHIFT{1'b0}}})
         + bsc_pkg::SENS_W'($signed(prod_s_ff[bsc_pkg::PROD_W-1:bsc_pkg::SENS_DT_SHIFT]));
      res_in.raw_press = rp2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff     <= dt_in;
      rp1_ff    <= raw_press;
      prod_t_ff <= prod_t_in;
      prod_o_ff <= prod_o_in;
      prod_s_ff <= prod_s_in;
      rp2_ff    <= rp1_ff;
      res_ff    <= res_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = res_ff;

endmodule

// File: rtl/bsc_press.sv
// stages four to six: split pressure product, recombine and shift, subtract offset
module bsc_press (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  bsc_pkg::calib_type                   in_data,
   output logic                                 out_valid,
   output logic signed [bsc_pkg::TEMP_W-1:0]    temp_centi,
   output logic signed [bsc_pkg::PRESS_W-1:0]   press_centi
);

   // stage four
   logic                                v4_ff;
   logic [bsc_pkg::PP_LO_W-1:0]         pp_lo_ff, pp_lo_in;
   logic signed [bsc_pkg::PP_HI_W-1:0]  pp_hi_ff, pp_hi_in;
   logic signed [bsc_pkg::OFF_W-1:0]    off4_ff;
   logic signed [bsc_pkg::TEMP_W-1:0]   temp4_ff;
   // stage five
   logic                                v5_ff;
   logic signed [bsc_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic signed [bsc_pkg::OFF_W-1:0]    off5_ff;
   logic signed [bsc_pkg::TEMP_W-1:0]   temp5_ff;
   logic [bsc_pkg::FULL_W-1:0]          full;
   // stage six
   logic                                v6_ff;
   logic signed [bsc_pkg::PRESS_W-1:0]  press_ff, press_in;
   logic signed [bsc_pkg::TEMP_W-1:0]   temp6_ff;
   logic signed [bsc_pkg::DIFF_W-1:0]   diff;

   // raw_p * sens as two 24 x 18 partial products
   always_comb begin
      pp_lo_in = bsc_pkg::PP_LO_W'(in_data.raw_press)
               * bsc_pkg::PP_LO_W'(in_data.sens[bsc_pkg::SPLIT_W-1:0]);
      pp_hi_in = bsc_pkg::PP_HI_W'($signed({1'b0, in_data.raw_press}))
               * bsc_pkg::PP_HI_W'($signed(in_data.sens[bsc_pkg::SENS_W-1:bsc_pkg::SPLIT_W]));
   end

   always_comb begin
      full    = (bsc_pkg::FULL_W'(pp_hi_ff) << bsc_pkg::SPLIT_W)
              + bsc_pkg::FULL_W'(pp_lo_ff);
      quot_in = $signed(full[bsc_pkg::FULL_W-1:bsc_pkg::PRESS_MUL_SHIFT]);
   end

   // the shifted difference is 26 bits wide, so the 32-bit clamp reduces to sign extension
   always_comb begin
      diff     = bsc_pkg::DIFF_W'(quot_ff) - bsc_pkg::DIFF_W'(off5_ff);
      press_in = bsc_pkg::PRESS_W'($signed(diff[bsc_pkg::DIFF_W-1:bsc_pkg::PRESS_OUT_SHIFT]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      off4_ff  <= in_data.off;
      temp4_ff <= in_data.temp;
      quot_ff  <= quot_in;
      off5_ff  <= off4_ff;
      temp5_ff <= temp4_ff;
      press_ff <= press_in;
      temp6_ff <= temp5_ff;
   end

   assign out_valid   = v6_ff;
   assign temp_centi  = temp6_ff;
   assign press_centi = press_ff;

endmodule
